// ===== hw/rtl/tmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// tmfs_pkg
// Shared constants, command codes and control/status types for the
// two-machine flow shop search unit.
// ----------------------------------------------------------------------------
package tmfs_pkg;

  localparam int MAX_JOBS_DEF  = 8;
  localparam int TIME_BITS_DEF = 16;

  localparam int IN_TIME_W   = 16;
  localparam int JOB_ID_W    = 4;
  localparam int MAKESPAN_W  = 21;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = 32;
  localparam int MAKESPAN_MAX = 2097151;

  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
  localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 4'd2;
  localparam logic [OP_W-1:0] OP_SKIP  = 4'd3;
  localparam logic [OP_W-1:0] OP_PUSH  = 4'd4;
  localparam logic [OP_W-1:0] OP_POP   = 4'd5;
  localparam logic [OP_W-1:0] OP_LEAF  = 4'd6;
  localparam logic [OP_W-1:0] OP_NEXT  = 4'd7;
  localparam logic [OP_W-1:0] OP_CLEAR = 4'd8;

  typedef struct packed {
    logic [OP_W-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic at_leaf;
    logic cursor_end;
    logic depth_zero;
    logic cand_take;
    logic emit_last;
  } status_t;

endpackage

// ===== hw/rtl/tmfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmfs_ctrl
// Sequencer: load jobs, run the branch-and-bound walk, emit the best order.
// ----------------------------------------------------------------------------
module tmfs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  input  tmfs_pkg::status_t status,
  output tmfs_pkg::cmd_t    cmd
);
  import tmfs_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_INIT = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op = OP_LOAD;
          if (s_tlast) state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.op     = OP_INIT;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.at_leaf) begin
          cmd.op = OP_LEAF;
        end else if (status.cursor_end) begin
          if (status.depth_zero) state_next = ST_EMIT;
          else cmd.op = OP_POP;
        end else if (status.cand_take) begin
          cmd.op = OP_PUSH;
        end else begin
          cmd.op = OP_SKIP;
        end
      end
      ST_EMIT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (status.emit_last) begin
            cmd.op     = OP_CLEAR;
            state_next = ST_LOAD;
          end else begin
            cmd.op = OP_NEXT;
          end
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

// ===== hw/rtl/tmfs_datapath.sv =====
// ----------------------------------------------------------------------------
// tmfs_datapath
// Job stores, choice and finish-time stacks, used mask, best order.
// ----------------------------------------------------------------------------
module tmfs_datapath #(
  parameter int MAX_JOBS  = tmfs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = tmfs_pkg::TIME_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  tmfs_pkg::cmd_t                  cmd,
  output tmfs_pkg::status_t               status,
  input  logic [tmfs_pkg::IN_TIME_W-1:0]  fill_time,
  input  logic [tmfs_pkg::IN_TIME_W-1:0]  cork_time,
  output logic [tmfs_pkg::JOB_ID_W-1:0]   job_id,
  output logic [tmfs_pkg::MAKESPAN_W-1:0] makespan,
  output logic                            last_place
);
  import tmfs_pkg::*;

  localparam int IDX_BITS = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_BITS = $clog2(MAX_JOBS + 1);
  localparam int FIN_BITS = TIME_BITS + $clog2(2 * MAX_JOBS);
  localparam int CMP_BITS = (FIN_BITS > MAKESPAN_W) ? FIN_BITS : MAKESPAN_W;

  logic [TIME_BITS-1:0] fill_store [MAX_JOBS];
  logic [TIME_BITS-1:0] cork_store [MAX_JOBS];
  logic [IDX_BITS-1:0]  choice     [MAX_JOBS];
  logic [IDX_BITS-1:0]  best_order [MAX_JOBS];
  logic [FIN_BITS-1:0]  ff_stack   [MAX_JOBS + 1];
  logic [FIN_BITS-1:0]  cf_stack   [MAX_JOBS + 1];

  logic [CNT_BITS-1:0] count;
  logic [CNT_BITS-1:0] depth;
  logic [CNT_BITS-1:0] cursor;
  logic [CNT_BITS-1:0] emit_k;
  logic [MAX_JOBS-1:0] used;
  logic [FIN_BITS-1:0] best;
  logic                found;

  logic [IDX_BITS-1:0] idx;
  logic [CNT_BITS-1:0] depth_m1;
  logic [IDX_BITS-1:0] back_idx;
  logic [FIN_BITS-1:0] ff_top;
  logic [FIN_BITS-1:0] cf_top;
  logic [FIN_BITS-1:0] ff_cand;
  logic [FIN_BITS-1:0] cf_start;
  logic [FIN_BITS-1:0] cf_cand;
  logic [CMP_BITS-1:0] best_ext;
  logic                leaf_better;

  assign idx      = cursor[IDX_BITS-1:0];
  assign depth_m1 = depth - CNT_BITS'(1);
  assign back_idx = choice[depth_m1[IDX_BITS-1:0]];
  assign ff_top   = ff_stack[depth];
  assign cf_top   = cf_stack[depth];
  assign ff_cand  = ff_top + FIN_BITS'(fill_store[idx]);
  assign cf_start = (ff_cand > cf_top) ? ff_cand : cf_top;
  assign cf_cand  = cf_start + FIN_BITS'(cork_store[idx]);
  assign leaf_better = !found || (cf_top < best);

  assign status.at_leaf    = (depth >= count);
  assign status.cursor_end = (cursor >= count);
  assign status.depth_zero = (depth == '0);
  assign status.cand_take  = !used[idx] && (!found || (cf_cand < best));
  assign status.emit_last  = (emit_k == depth_m1) || (emit_k == count - CNT_BITS'(1));

  assign best_ext   = CMP_BITS'(best);
  assign job_id     = JOB_ID_W'(best_order[emit_k[IDX_BITS-1:0]]) + JOB_ID_W'(1);
  assign makespan   = (best_ext > CMP_BITS'(MAKESPAN_MAX)) ? MAKESPAN_W'(MAKESPAN_MAX)
                                                           : MAKESPAN_W'(best_ext);
  assign last_place = (emit_k == count - CNT_BITS'(1));

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && count < CNT_BITS'(MAX_JOBS)) begin
      fill_store[count[IDX_BITS-1:0]] <= TIME_BITS'(fill_time);
      cork_store[count[IDX_BITS-1:0]] <= TIME_BITS'(cork_time);
    end
    if (cmd.op == OP_INIT) begin
      ff_stack[0] <= '0;
      cf_stack[0] <= '0;
    end
    if (cmd.op == OP_PUSH) begin
      choice[depth[IDX_BITS-1:0]] <= idx;
      ff_stack[depth + CNT_BITS'(1)] <= ff_cand;
      cf_stack[depth + CNT_BITS'(1)] <= cf_cand;
    end
    if (cmd.op == OP_LEAF && leaf_better) begin
      best_order <= choice;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      depth  <= '0;
      cursor <= '0;
      emit_k <= '0;
      used   <= '0;
      best   <= '0;
      found  <= 1'b0;
    end else begin
      case (cmd.op) inside
        OP_LOAD: begin
          if (count < CNT_BITS'(MAX_JOBS)) count <= count + CNT_BITS'(1);
        end
        OP_INIT: begin
          depth  <= '0;
          cursor <= '0;
          emit_k <= '0;
          used   <= '0;
          best   <= '0;
          found  <= 1'b0;
        end
        OP_SKIP: cursor <= cursor + CNT_BITS'(1);
        OP_PUSH: begin
          used[idx] <= 1'b1;
          depth     <= depth + CNT_BITS'(1);
          cursor    <= '0;
        end
        OP_LEAF, OP_POP: begin
          if (cmd.op == OP_LEAF && leaf_better) begin
            found <= 1'b1;
            best  <= cf_top;
          end
          depth          <= depth_m1;
          cursor         <= CNT_BITS'(back_idx) + CNT_BITS'(1);
          used[back_idx] <= 1'b0;
        end
        OP_NEXT: emit_k <= emit_k + CNT_BITS'(1);
        OP_CLEAR: begin
          count  <= '0;
          depth  <= '0;
          cursor <= '0;
          emit_k <= '0;
          used   <= '0;
          best   <= '0;
          found  <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= count) else $error("search depth beyond job count");

  a_mask_depth: assert property (@(posedge clk) disable iff (rst)
    $countones(used) == int'(depth)) else $error("used mask out of step with depth");

  a_push_depth: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_PUSH |=> depth == $past(depth) + CNT_BITS'(1))
    else $error("push did not advance depth");

endmodule

// ===== hw/rtl/two_machine_flow_shop_search_unit.sv =====
// ----------------------------------------------------------------------------
// two_machine_flow_shop_search_unit
// Loads jobs one beat per cycle; the beat with tlast starts a depth-first
// branch-and-bound search. Search: a setup step, then for each job slot
// scanned a skip or a push, a step per pop or leaf, and a step to leave.
// Results then stream out one beat per accepted cycle, one beat per stored
// job; no input is taken during search or output. Synchronous active-high
// reset clears the control state and counters; job stores are not reset.
// ----------------------------------------------------------------------------
module two_machine_flow_shop_search_unit #(
  parameter int MAX_JOBS  = tmfs_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = tmfs_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [tmfs_pkg::S_DATA_W-1:0] s_tdata,  // fill_time[15:0], cork_time[31:16]
  input  logic                          s_tlast,  // last_job
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tmfs_pkg::M_DATA_W-1:0] m_tdata,  // job_id[3:0], makespan[24:4], zero pad
  output logic                          m_tlast   // last_place
);
  import tmfs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic [JOB_ID_W-1:0]   job_id;
  logic [MAKESPAN_W-1:0] makespan;

  tmfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  tmfs_datapath #(
    .MAX_JOBS  (MAX_JOBS),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .fill_time  (s_tdata[IN_TIME_W-1:0]),
    .cork_time  (s_tdata[2*IN_TIME_W-1:IN_TIME_W]),
    .job_id     (job_id),
    .makespan   (makespan),
    .last_place (m_tlast)
  );

  assign m_tdata = {{(M_DATA_W - JOB_ID_W - MAKESPAN_W){1'b0}}, makespan, job_id};

endmodule

// ===== tb/sv/tb_two_machine_flow_shop_search_unit.sv =====
// ----------------------------------------------------------------------------
// tb_two_machine_flow_shop_search_unit
// Streams job sets into the search unit with random idling on both sides.
// A local branch-and-bound search predicts each best order and makespan.
// Every output beat is checked against the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_two_machine_flow_shop_search_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tmfs_pkg::*;

  localparam int NJ = MAX_JOBS_DEF;
  localparam int WATCHDOG = 5000000;

  typedef struct packed {
    logic [15:0] fill;
    logic [15:0] cork;
    logic        last;
  } job_t;

  typedef struct packed {
    logic [JOB_ID_W-1:0]   id;
    logic [MAKESPAN_W-1:0] span;
    logic                  last;
  } place_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic m_tlast;

  job_t   pending_jobs[$];
  place_t best_places[$];
  int     src_idle_pct = 0;
  int     snk_stall_pct = 0;
  bit     hold_src = 1'b0;
  bit     stim_done = 1'b0;
  int     errors = 0;
  int     quiet_cycles = 0;

  logic [15:0] fill_mem[NJ];
  logic [15:0] cork_mem[NJ];
  int          loaded = 0;

  two_machine_flow_shop_search_unit i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exhaustive search with pruning, same visiting order as the hardware
  function automatic void search_best(input int n);
    longint ff[NJ+1], cf[NJ+1], best_span, nf, nc;
    int     pick[NJ], best_pick[NJ], d, cur, i;
    bit     used[NJ], found, down;
    place_t p;
    found = 1'b0; best_span = 0; d = 0; cur = 0; ff[0] = 0; cf[0] = 0;
    for (i = 0; i < NJ; i++) begin
      used[i] = 1'b0; pick[i] = 0; best_pick[i] = 0;
    end
    forever begin
      down = 1'b0;
      if (d >= n) begin
        if (!found || cf[d] < best_span) begin
          found = 1'b1; best_span = cf[d]; best_pick = pick;
        end
      end else begin
        for (i = cur; i < n; i++) begin
          if (used[i]) continue;
          nf = ff[d] + fill_mem[i];
          nc = ((nf > cf[d]) ? nf : cf[d]) + cork_mem[i];
          if (!found || nc < best_span) begin
            pick[d] = i; used[i] = 1'b1; ff[d+1] = nf; cf[d+1] = nc;
            d = d + 1; cur = 0; down = 1'b1;
            break;
          end
        end
      end
      if (down) continue;
      if (d == 0) break;
      d = d - 1;
      cur = pick[d] + 1;
      used[pick[d]] = 1'b0;
    end
    if (best_span > MAKESPAN_MAX) best_span = MAKESPAN_MAX;
    for (i = 0; i < n; i++) begin
      p.id = JOB_ID_W'(best_pick[i] + 1);
      p.span = MAKESPAN_W'(best_span);
      p.last = (i == n - 1);
      best_places = {best_places, p};
    end
  endfunction

  // driver
  always @(posedge clk) begin
    job_t j;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        j.fill = s_tdata[15:0]; j.cork = s_tdata[31:16]; j.last = s_tlast;
        if (loaded < NJ) begin
          fill_mem[loaded] = j.fill; cork_mem[loaded] = j.cork; loaded++;
        end
        if (j.last) begin
          search_best(loaded);
          loaded = 0;
        end
      end
      if ((!s_tvalid || s_tready) ) begin
        if (pending_jobs.size() != 0 && !hold_src &&
            $urandom_range(99) >= src_idle_pct) begin
          j = pending_jobs.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {j.cork, j.fill};
          s_tlast <= j.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    place_t p;
    if (!rst) begin
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (best_places.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat %h last %b", $time, m_tdata, m_tlast);
        end else begin
          p = best_places.pop_front();
          if (m_tdata[3:0] !== p.id || m_tdata[24:4] !== p.span ||
              m_tdata[31:25] !== '0 || m_tlast !== p.last) begin
            errors++;
            $display("%0t: expected id %0d span %0d last %b, got id %0d span %0d last %b",
                     $time, p.id, p.span, p.last, m_tdata[3:0], m_tdata[24:4], m_tlast);
          end
        end
      end
    end
  end

  function automatic logic [15:0] rand_time(input int kind);
    case (kind)
      0: return 16'($urandom_range(15));
      1: return 16'hFFFF - 16'($urandom_range(3));
      default: return 16'($urandom);
    endcase
  endfunction

  // one set of n jobs, last flagged; n > NJ overflows the store
  task automatic add_set(input int n, input int kind);
    job_t j;
    for (int k = 0; k < n; k++) begin
      j.fill = rand_time(kind);
      j.cork = rand_time(kind);
      j.last = (k == n - 1);
      pending_jobs = {pending_jobs, j};
    end
  endtask

  task automatic drain();
    while (pending_jobs.size() != 0 || s_tvalid || best_places.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int count;
    job_t j;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // directed: single job, extremes, ties, overflow
    j = '{16'h0000, 16'h0000, 1'b1}; pending_jobs = {pending_jobs, j};
    j = '{16'hFFFF, 16'hFFFF, 1'b1}; pending_jobs = {pending_jobs, j};
    add_set(NJ, 1);
    for (int k = 0; k < 4; k++) begin
      j = '{16'h0005, 16'h0005, k == 3}; pending_jobs = {pending_jobs, j};
    end
    add_set(NJ + 2, 2);
    drain();
    // every result is in; hold the source off before the random phases
    hold_src = 1'b1;
    repeat (20) @(posedge clk);
    hold_src = 1'b0;
    count = 0;
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 72 : 21) : 0;
      snk_stall_pct = (ph == 2) ? 72 : ((ph == 3) ? 21 : 0);
      while (count < (ph + 1) * 90) begin
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(NJ + 1, NJ) :
            $urandom_range(NJ - 2, 1);
        add_set(n, $urandom_range(3));
        count += n;
      end
      drain();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    repeat (50) @(posedge clk);
    if (errors == 0 && best_places.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    wait (!rst);
    wait (quiet_cycles >= WATCHDOG);
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
